// File: rtl/core/usb_mouse_to_ps2_frames_defines.svh
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef USB_MOUSE_TO_PS2_FRAMES_DEFINES_SVH
`define USB_MOUSE_TO_PS2_FRAMES_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UMPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("umps: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define UMPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("umps: next-cycle check failed");

`endif

// File: rtl/core/umps_pkg.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: package
// Item types, packet constants and the PS/2 frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package umps_pkg;

    localparam int FRAMES  = 4;
    localparam int FRAME_W = 11;
    localparam int IDX_W   = $clog2(FRAMES);

    // Index of the closing frame of a packet.
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    localparam logic [3:0] MIN_LENGTH    = 4'd3;
    localparam logic [7:0] STATUS_ALWAYS = 8'h08;
    localparam logic [7:0] STATUS_YNEG   = 8'h10;
    localparam logic [7:0] STATUS_XNEG   = 8'h20;
    localparam logic [7:0] WHEEL_BYTE    = 8'h00;

    typedef struct packed {
        logic [3:0]        report_length;
        logic [7:0]        button_bits;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_bits;
        logic               last_frame;
    } t_out;

    typedef struct packed {
        logic [1:0]        buttons;
        logic signed [7:0] half_x;
        logic signed [7:0] half_y;
    } t_dec;

    typedef logic [FRAMES-1:0][FRAME_W-1:0] t_frames;

    // Start bit 0, data LSB first, odd parity, stop bit 1.
    function automatic logic [FRAME_W-1:0] make_frame(input logic [7:0] data);
        return {1'b1, ~^data, data, 1'b0};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/umps_decode.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: decode stage
// Drops short reports and halves both motion bytes toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module umps_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire umps_pkg::t_in i_item,
    output logic               o_stall,
    output logic               o_valid,
    output umps_pkg::t_dec     o_dec,
    input  wire logic          i_stall
);

    logic           r_valid;
    logic           n_valid;
    umps_pkg::t_dec r_dec;
    umps_pkg::t_dec n_dec;
    logic           w_en;
    logic [8:0]     w_sum_x;
    logic [8:0]     w_sum_y;

    assign w_en = !r_valid || !i_stall;

    // Adding one to a negative value before the shift rounds toward zero.
    assign w_sum_x = {i_item.move_x[7], i_item.move_x} + {8'd0, i_item.move_x[7]};
    assign w_sum_y = {i_item.move_y[7], i_item.move_y} + {8'd0, i_item.move_y[7]};

    always_comb begin
        n_valid       = i_valid && (i_item.report_length >= umps_pkg::MIN_LENGTH);
        n_dec.buttons = i_item.button_bits[1:0];
        n_dec.half_x  = w_sum_x[8:1];
        n_dec.half_y  = w_sum_y[8:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_stall = !w_en;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

// File: rtl/core/umps_frame.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: frame build stage
// Forms the status byte and wraps all four packet bytes into PS/2 frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module umps_frame (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire umps_pkg::t_dec i_dec,
    output logic                o_stall,
    output logic                o_valid,
    output umps_pkg::t_frames   o_frames,
    input  wire logic           i_stall
);

    logic              r_valid;
    umps_pkg::t_frames r_frames;
    umps_pkg::t_frames n_frames;
    logic              w_en;
    logic [7:0]        w_new_y;
    logic [7:0]        w_status;

    assign w_en = !r_valid || !i_stall;

    // PS/2 counts Y upward, so the halved value changes sign.
    assign w_new_y = 8'd0 - i_dec.half_y;

    always_comb begin
        w_status = {6'd0, i_dec.buttons} | umps_pkg::STATUS_ALWAYS;
        if (w_new_y[7]) begin
            w_status = w_status | umps_pkg::STATUS_YNEG;
        end
        if (i_dec.half_x[7]) begin
            w_status = w_status | umps_pkg::STATUS_XNEG;
        end
        n_frames[0] = umps_pkg::make_frame(w_status);
        n_frames[1] = umps_pkg::make_frame(w_new_y);
        n_frames[2] = umps_pkg::make_frame(i_dec.half_x);
        n_frames[3] = umps_pkg::make_frame(umps_pkg::WHEEL_BYTE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_frames <= n_frames;
        end
    end

    assign o_stall  = !w_en;
    assign o_valid  = r_valid;
    assign o_frames = r_frames;

endmodule

`default_nettype wire

// File: rtl/core/umps_serial.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: frame serializer
// Holds one packet and moves its frames, one per cycle while the output is not stalled, to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module umps_serial (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire umps_pkg::t_frames i_frames,
    output logic                   o_stall,
    output logic                   o_valid,
    output umps_pkg::t_out         o_item,
    input  wire logic              i_stall
);

    logic                      r_pkt_valid;
    logic                      n_pkt_valid;
    logic [umps_pkg::IDX_W-1:0] r_idx;
    logic [umps_pkg::IDX_W-1:0] n_idx;
    umps_pkg::t_frames         r_pkt;
    logic                      r_out_valid;
    logic                      n_out_valid;
    umps_pkg::t_out            r_out;
    umps_pkg::t_out            n_out;
    logic                      w_out_load;
    logic                      w_last;
    logic                      w_pkt_take;

    assign w_out_load = !r_out_valid || !i_stall;
    assign w_last     = (r_idx == umps_pkg::LAST_IDX);
    // A new packet may land in the same cycle its predecessor's last frame leaves.
    assign w_pkt_take = !r_pkt_valid || (w_out_load && w_last);

    always_comb begin
        n_out_valid      = w_out_load ? r_pkt_valid : r_out_valid;
        n_out.frame_bits = r_pkt[r_idx];
        n_out.last_frame = w_last;
        n_pkt_valid      = r_pkt_valid;
        n_idx            = r_idx;
        if (w_pkt_take) begin
            n_pkt_valid = i_valid;
            n_idx       = '0;
        end else if (w_out_load) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pkt_valid <= n_pkt_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pkt_take) begin
            r_pkt <= i_frames;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !w_pkt_take;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/usb_mouse_to_ps2_frames.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames
// Converts USB boot-mouse reports into four-frame PS/2 mouse packets.
// ----------------------------------------------------------------------------
// Each accepted report of three or more bytes yields four 11-bit PS/2 frames
// in the order status, Y, X and wheel (always zero), with last_frame set on
// the fourth; shorter reports are consumed and produce nothing. The block is
// a three-stage pipeline (decode, frame build, serializer); a report moves
// through the decode, frame and packet registers to the output register. The
// output channel carries one frame per cycle while the receiver does not stall,
// so the serializer, at four frames per report, limits the sustained rate;
// while it drains a packet, the next report is already taken and held ready
// in the stages before it, and short reports pass at one per cycle unless the
// decode stage stalls. Either side may stall at any time without loss or duplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usb_mouse_to_ps2_frames (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire umps_pkg::t_in i_item,
    output logic               o_stall,
    output logic               o_valid,
    output umps_pkg::t_out     o_item,
    input  wire logic          i_stall
);

    // Decode to frame build.
    logic              w_dec_valid;
    umps_pkg::t_dec    w_dec;
    logic              w_dec_stall;

    // Frame build to serializer.
    logic              w_frm_valid;
    umps_pkg::t_frames w_frames;
    logic              w_frm_stall;

    // Stage one filters short reports and halves the motion bytes.
    umps_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (w_dec_valid),
        .o_dec   (w_dec),
        .i_stall (w_dec_stall)
    );

    // Stage two negates Y, builds the status byte and all four frames.
    umps_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dec_valid),
        .i_dec    (w_dec),
        .o_stall  (w_dec_stall),
        .o_valid  (w_frm_valid),
        .o_frames (w_frames),
        .i_stall  (w_frm_stall)
    );

    // Stage three sends the packet one frame per output item.
    umps_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_frm_valid),
        .i_frames (w_frames),
        .o_stall  (w_frm_stall),
        .o_valid  (o_valid),
        .o_item   (o_item),
        .i_stall  (i_stall)
    );

endmodule

`default_nettype wire

// File: rtl/core/umps_checker.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: port checker
// Watches the output channel for frame format and packet continuity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "usb_mouse_to_ps2_frames_defines.svh"

module umps_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire umps_pkg::t_out o_item,
    input wire logic           i_stall
);

    logic w_frame_ok;

    // Start bit low, stop bit high, and odd parity over data and parity bit.
    assign w_frame_ok = (o_item.frame_bits[0] == 1'b0) &&
                        (o_item.frame_bits[10] == 1'b1) &&
                        (^o_item.frame_bits[9:1] == 1'b1);

    // A stalled output item stays in place.
    `UMPS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_item))

    // Every frame has its start, stop and odd parity bits right.
    `UMPS_ASSERT_SAME(a_frame_form, o_valid, w_frame_ok)

    // The frames of one packet follow each other without a gap.
    `UMPS_ASSERT_NEXT(a_packet_run, o_valid && !i_stall && !o_item.last_frame, o_valid)

    // The closing frame always carries the zero wheel byte.
    `UMPS_ASSERT_SAME(a_last_zero, o_valid && o_item.last_frame, o_item.frame_bits == 11'h600)

endmodule

bind usb_mouse_to_ps2_frames umps_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_item  (o_item),
    .i_stall (i_stall)
);

`default_nettype wire

// File: dv/usb_mouse_to_ps2_frames_tb.sv
// ----------------------------------------------------------------------------
// USB mouse to PS/2 frames: testbench
// Sends boot-mouse reports through the converter and checks every PS/2 frame.
// ----------------------------------------------------------------------------
// Each accepted report is turned into its four expected frames by a local
// packet builder, and the frames are queued in order. A monitor compares
// each frame taken from the output against the oldest queued one. Directed
// tests cover short and long reports, the motion extremes and the button
// byte; a random test follows, and a back-pressure test holds the output
// off long enough for the converter to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_mouse_to_ps2_frames_tb;

    localparam int MAX_REPORTED = 10;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    umps_pkg::t_in  i_item;
    logic           o_stall;
    logic           o_valid;
    umps_pkg::t_out o_item;
    logic           i_stall;

    // Frames still owed by the converter, oldest first.
    umps_pkg::t_out frames_due[$];

    int fails;
    // When set, neither side inserts random idle cycles.
    bit steady;
    // A hold-off length handed to the receiver process, in cycles.
    int hold_request;

    usb_mouse_to_ps2_frames u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_item (o_item),
        .i_stall(i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("usb_mouse_to_ps2_frames_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Packet builder
    // ------------------------------------------------------------------------

    // Wraps one data byte in a PS/2 frame: start 0, data LSB first, odd
    // parity, stop 1.
    function automatic logic [umps_pkg::FRAME_W-1:0] ps2_frame(input logic [7:0] data);
        logic parity;
        parity = 1'b1;
        for (int i = 0; i < 8; i++) begin
            parity = parity ^ data[i];
        end
        return {1'b1, parity, data, 1'b0};
    endfunction

    // Halves a signed motion byte, rounding toward zero.
    function automatic int halve_toward_zero(input logic signed [7:0] v);
        int w;
        w = v;
        return (w < 0) ? -((-w) / 2) : (w / 2);
    endfunction

    // Queues the four frames one report must produce; short reports owe
    // nothing.
    function automatic void queue_packet(input umps_pkg::t_in rpt);
        int             new_x;
        int             new_y;
        logic [7:0]     status;
        logic [7:0]     bytes[umps_pkg::FRAMES];
        umps_pkg::t_out frm;
        if (rpt.report_length < umps_pkg::MIN_LENGTH) begin
            return;
        end
        new_x = halve_toward_zero(rpt.move_x);
        // Y points the other way on PS/2, so it is negated after halving.
        new_y = -halve_toward_zero(rpt.move_y);
        status = {6'b0, rpt.button_bits[1:0]} | umps_pkg::STATUS_ALWAYS;
        if (new_y < 0) begin
            status = status | umps_pkg::STATUS_YNEG;
        end
        if (new_x < 0) begin
            status = status | umps_pkg::STATUS_XNEG;
        end
        bytes[0] = status;
        bytes[1] = new_y[7:0];
        bytes[2] = new_x[7:0];
        bytes[3] = umps_pkg::WHEEL_BYTE;
        for (int k = 0; k < umps_pkg::FRAMES; k++) begin
            frm.frame_bits = ps2_frame(bytes[k]);
            frm.last_frame = (k == umps_pkg::FRAMES - 1);
            frames_due.push_back(frm);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        if (fails < MAX_REPORTED) begin
            $display("%0t: %s", $realtime, msg);
        end
        fails++;
    endfunction

    // A frame is taken at a rising edge where o_valid is high and i_stall is
    // low. i_stall changes only on falling edges, so it is stable here.
    always @(posedge i_clk) begin : check_frames
        umps_pkg::t_out due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frames_due.size() == 0) begin
                note_failure($sformatf("frame with none due: bits %03h last %0b",
                                       o_item.frame_bits, o_item.last_frame));
            end else begin
                due = frames_due.pop_front();
                if (o_item.frame_bits !== due.frame_bits ||
                    o_item.last_frame !== due.last_frame) begin
                    note_failure($sformatf(
                        "frame mismatch: expected bits %03h last %0b, got bits %03h last %0b",
                        due.frame_bits, due.last_frame,
                        o_item.frame_bits, o_item.last_frame));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls in runs, mostly short with a few long ones, and
    // a long hold-off when a test asks for one.
    // ------------------------------------------------------------------------

    initial begin : receiver
        int   run_left;
        logic run_stall;
        int   hold_left;
        run_left  = 0;
        run_stall = 1'b0;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (steady) begin
                i_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_stall = ($urandom_range(0, 99) < 35);
                    run_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                             : $urandom_range(1, 4);
                end
                i_stall <= run_stall;
                run_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Idle cycles after an item: usually none or a few, now and then a long
    // pause.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic umps_pkg::t_in make_report(input int len, input int btn,
                                                  input int mx, input int my);
        umps_pkg::t_in rpt;
        rpt.report_length = len[3:0];
        rpt.button_bits   = btn[7:0];
        rpt.move_x        = mx[7:0];
        rpt.move_y        = my[7:0];
        return rpt;
    endfunction

    // Offers one report, holds it until accepted, then idles for the requested gap.
    // With no gap, valid stays high and the next call replaces the payload on
    // the following falling edge.
    task automatic send_report(input umps_pkg::t_in rpt, input int gap);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= rpt;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        queue_packet(rpt);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reports under three bytes are swallowed; the ones around them must
    // still come out in order.
    task automatic test_short_reports();
        send_report(make_report(0, 8'hFF, -128, 127), pick_gap());
        send_report(make_report(1, 8'h03, 5, -5), 0);
        send_report(make_report(2, 8'h01, 127, -128), 0);
        send_report(make_report(3, 8'h02, 10, 10), 0);
        send_report(make_report(2, 8'hAA, -7, 9), pick_gap());
    endtask

    // Lengths above three behave like three, including the top of the field.
    task automatic test_long_reports();
        send_report(make_report(8, 8'h01, 33, -33), pick_gap());
        send_report(make_report(9, 8'h02, -64, 64), pick_gap());
        send_report(make_report(15, 8'h03, 1, -1), 0);
    endtask

    // Motion extremes: -128 halves to -64, and Y of -128 ends up +64. Odd
    // values check that the halving truncates toward zero.
    task automatic test_motion_extremes();
        send_report(make_report(3, 8'h00, -128, -128), pick_gap());
        send_report(make_report(3, 8'h00, 127, 127), 0);
        send_report(make_report(3, 8'h00, -1, -1), 0);
        send_report(make_report(3, 8'h00, 1, 1), pick_gap());
        send_report(make_report(3, 8'h00, 0, 0), 0);
        send_report(make_report(4, 8'h00, -3, 3), 0);
        send_report(make_report(3, 8'h00, 2, -2), pick_gap());
    endtask

    // Only the two low button bits reach the status byte.
    task automatic test_buttons();
        send_report(make_report(3, 8'hFF, 4, -4), pick_gap());
        send_report(make_report(3, 8'hFC, -4, 4), 0);
        send_report(make_report(3, 8'h01, 0, 0), 0);
        send_report(make_report(3, 8'h02, 0, 0), pick_gap());
        send_report(make_report(3, 8'h55, 100, -100), 0);
    endtask

    // Mostly full reports with random content, some short ones mixed in.
    // A middle stretch runs with no idling on either side.
    task automatic test_random_reports(input int count);
        int len;
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 2) && (n < count / 2 + 40);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(3, 15)
                                               : $urandom_range(0, 2);
            send_report(make_report(len, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 255)),
                        pick_gap());
        end
        steady = 1'b0;
    endtask

    // The receiver holds off for a long stretch while reports keep coming,
    // so the converter fills up and must stall its input.
    task automatic test_backpressure();
        hold_request = 80;
        for (int n = 0; n < 12; n++) begin
            send_report(make_report($urandom_range(3, 15), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 255)), 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        fails        = 0;
        steady       = 1'b0;
        hold_request = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_item       = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_reports();
        test_long_reports();
        test_motion_extremes();
        test_buttons();
        test_random_reports(270);
        test_backpressure();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Wait for every owed frame, then watch a little longer for strays.
        while (frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (frames_due.size() != 0) begin
            note_failure($sformatf("%0d frames never arrived", frames_due.size()));
        end
        if (fails == 0) begin
            $display("usb_mouse_to_ps2_frames_tb OK");
        end else begin
            $display("usb_mouse_to_ps2_frames_tb NOT OK");
        end
        $finish;
    end

endmodule
